FILE: rtl/sl_pkg.sv
// Shared types, codes and keyword tables for the source lexer.
`timescale 1ns / 1ps

package sl_pkg;

    localparam int ADDR_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int              FIELD_W   = 24;
    localparam logic [23:0]     FIELD_MAX = 24'hFFFFFF;

    // token kinds
    localparam logic [5:0] KIND_EOF       = 6'd0;
    localparam logic [5:0] KIND_ERROR     = 6'd1;
    localparam logic [5:0] KIND_IDENT     = 6'd2;
    localparam logic [5:0] KIND_NUMBER    = 6'd3;
    localparam logic [5:0] KIND_STRING    = 6'd4;
    localparam logic [5:0] KIND_LPAREN    = 6'd5;
    localparam logic [5:0] KIND_RPAREN    = 6'd6;
    localparam logic [5:0] KIND_LBRACE    = 6'd7;
    localparam logic [5:0] KIND_RBRACE    = 6'd8;
    localparam logic [5:0] KIND_COMMA     = 6'd9;
    localparam logic [5:0] KIND_DOT       = 6'd10;
    localparam logic [5:0] KIND_MINUS     = 6'd11;
    localparam logic [5:0] KIND_PLUS      = 6'd12;
    localparam logic [5:0] KIND_SEMI      = 6'd13;
    localparam logic [5:0] KIND_SLASH     = 6'd14;
    localparam logic [5:0] KIND_STAR      = 6'd15;
    localparam logic [5:0] KIND_BANG      = 6'd16;
    localparam logic [5:0] KIND_BANG_EQ   = 6'd17;
    localparam logic [5:0] KIND_ASSIGN    = 6'd18;
    localparam logic [5:0] KIND_EQ_EQ     = 6'd19;
    localparam logic [5:0] KIND_GT        = 6'd20;
    localparam logic [5:0] KIND_GT_EQ     = 6'd21;
    localparam logic [5:0] KIND_LT        = 6'd22;
    localparam logic [5:0] KIND_LT_EQ     = 6'd23;
    localparam logic [5:0] KIND_PIPE      = 6'd24;
    localparam logic [5:0] KIND_PIPE_PIPE = 6'd25;
    localparam logic [5:0] KIND_AMP       = 6'd26;
    localparam logic [5:0] KIND_AMP_AMP   = 6'd27;
    localparam logic [5:0] KIND_ELSE      = 6'd28;
    localparam logic [5:0] KIND_FOR       = 6'd29;
    localparam logic [5:0] KIND_FUNCTION  = 6'd30;
    localparam logic [5:0] KIND_IF        = 6'd31;
    localparam logic [5:0] KIND_RETURN    = 6'd32;
    localparam logic [5:0] KIND_VAR       = 6'd33;
    localparam logic [5:0] KIND_WHILE     = 6'd34;

    // error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    // keyword candidates
    typedef logic [3:0] kw_t;
    localparam kw_t KW_NONE     = 4'd0;
    localparam kw_t KW_ELSE     = 4'd1;
    localparam kw_t KW_FOR      = 4'd2;
    localparam kw_t KW_FUNCTION = 4'd3;
    localparam kw_t KW_FN       = 4'd4;
    localparam kw_t KW_IF       = 4'd5;
    localparam kw_t KW_RETURN   = 4'd6;
    localparam kw_t KW_VAR      = 4'd7;
    localparam kw_t KW_WHILE    = 4'd8;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [1:0]  error_code;
    } tok_t;

    // all tokens caused by one source byte
    typedef struct packed {
        logic [1:0]       cnt;
        logic [23:0]      line_number;
        tok_t [2:0]       toks;
    } bundle_t;

    function automatic kw_t kw_first(input logic [7:0] c);
        kw_t t;
        unique case (c)
            "e":     t = KW_ELSE;
            "f":     t = KW_FOR;
            "i":     t = KW_IF;
            "r":     t = KW_RETURN;
            "v":     t = KW_VAR;
            "w":     t = KW_WHILE;
            default: t = KW_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input kw_t t);
        logic [3:0] n;
        unique case (t)
            KW_ELSE:     n = 4'd4;
            KW_FOR:      n = 4'd3;
            KW_FUNCTION: n = 4'd8;
            KW_FN:       n = 4'd2;
            KW_IF:       n = 4'd2;
            KW_RETURN:   n = 4'd6;
            KW_VAR:      n = 4'd3;
            KW_WHILE:    n = 4'd5;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] kw_kind(input kw_t t);
        logic [5:0] k;
        unique case (t)
            KW_ELSE:     k = KIND_ELSE;
            KW_FOR:      k = KIND_FOR;
            KW_FUNCTION: k = KIND_FUNCTION;
            KW_FN:       k = KIND_FUNCTION;
            KW_IF:       k = KIND_IF;
            KW_RETURN:   k = KIND_RETURN;
            KW_VAR:      k = KIND_VAR;
            KW_WHILE:    k = KIND_WHILE;
            default:     k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] kw_char(input kw_t t, input logic [2:0] idx);
        logic [63:0] s;
        unique case (t)
            KW_ELSE:     s = {"else", 32'h0};
            KW_FOR:      s = {"for", 40'h0};
            KW_FUNCTION: s = "function";
            KW_FN:       s = {"fn", 48'h0};
            KW_IF:       s = {"if", 48'h0};
            KW_RETURN:   s = {"return", 16'h0};
            KW_VAR:      s = {"var", 40'h0};
            KW_WHILE:    s = {"while", 24'h0};
            default:     s = 64'h0;
        endcase
        return s[{3'd7 - idx, 3'b000} +: 8];
    endfunction

    // advance the keyword candidate by one identifier character at index idx
    function automatic kw_t kw_step(input kw_t t, input logic idx_small,
                                    input logic [2:0] idx, input logic [7:0] c);
        kw_t r;
        r = KW_NONE;
        if (t != KW_NONE && t <= KW_WHILE && idx_small) begin
            if (t == KW_FOR && idx == 3'd1) begin
                unique case (c)
                    "o":     r = KW_FOR;
                    "u":     r = KW_FUNCTION;
                    "n":     r = KW_FN;
                    default: r = KW_NONE;
                endcase
            end
            else if ({1'b0, idx} < kw_len(t) && kw_char(t, idx) == c) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] op_second(input logic [7:0] first);
        logic [7:0] s;
        unique case (first)
            "|":     s = "|";
            "&":     s = "&";
            default: s = "=";
        endcase
        return s;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] first, input logic paired);
        logic [5:0] k;
        unique case (first)
            "!":     k = paired ? KIND_BANG_EQ   : KIND_BANG;
            "=":     k = paired ? KIND_EQ_EQ     : KIND_ASSIGN;
            ">":     k = paired ? KIND_GT_EQ     : KIND_GT;
            "<":     k = paired ? KIND_LT_EQ     : KIND_LT;
            "|":     k = paired ? KIND_PIPE_PIPE : KIND_PIPE;
            default: k = paired ? KIND_AMP_AMP   : KIND_AMP;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/sl_byte_if.sv
// Valid/ready channel that carries one source byte per word.
`timescale 1ns / 1ps

interface sl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

FILE: rtl/sl_token_if.sv
// Valid/ready channel that carries one token per word.
`timescale 1ns / 1ps

interface sl_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic [23:0] line_number;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output start_offset, output token_length,
                    output line_number, output error_code, output last, input ready);
    modport sink   (input valid, input kind, input start_offset, input token_length,
                    input line_number, input error_code, input last, output ready);
endinterface

FILE: rtl/sl_front.sv
// Scanner front end: takes one byte a cycle while full is low and classifies it into a token bundle.
`timescale 1ns / 1ps

module sl_front #(
    parameter int ADDR_BITS = sl_pkg::ADDR_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    sl_byte_if.sink          src,
    input  logic             full,
    output logic             push,
    output sl_pkg::bundle_t  bundle
);

    localparam int LW = (ADDR_BITS + 1 > 24) ? ADDR_BITS + 1 : 24;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUMBER  = 4'd2;
    localparam logic [3:0] M_NUMDOT  = 4'd3;
    localparam logic [3:0] M_FRAC    = 4'd4;
    localparam logic [3:0] M_STRING  = 4'd5;
    localparam logic [3:0] M_COMMENT = 4'd6;
    localparam logic [3:0] M_SLASH   = 4'd7;
    localparam logic [3:0] M_OP2     = 4'd8;

    localparam logic [7:0] CH_CR     = 8'h0D;

    logic [3:0]           mode_reg, mode_next;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;
    logic [23:0]          line_reg, line_next;
    logic [ADDR_BITS-1:0] tb_reg, tb_next;
    logic [7:0]           pend_reg, pend_next;
    sl_pkg::kw_t          kw_reg, kw_next;

    logic                 accept;
    logic [7:0]           c;
    logic                 is_alpha, is_dig;
    logic [ADDR_BITS-1:0] diff;
    logic [ADDR_BITS-1:0] dot_pos;
    logic [LW-1:0]        dot_len;
    logic [1:0]           m_cnt;
    sl_pkg::tok_t         m_tok0, m_tok1, i_tok;
    logic                 i_en;
    logic                 to_idle;
    logic                 ended;
    logic                 line_inc;
    logic [5:0]           word_kind;

    function automatic logic [23:0] sat(input logic [LW-1:0] v);
        return (v > LW'(sl_pkg::FIELD_MAX)) ? sl_pkg::FIELD_MAX : v[23:0];
    endfunction

    function automatic sl_pkg::tok_t mk(input logic [5:0] kind, input logic [LW-1:0] start,
                                        input logic [LW-1:0] len, input logic [1:0] err);
        sl_pkg::tok_t t;
        t.kind         = kind;
        t.start_offset = sat(start);
        t.token_length = sat(len);
        t.error_code   = err;
        return t;
    endfunction

    assign src.ready = !full;
    assign accept    = src.valid && src.ready;
    assign c         = src.ch;

    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign is_dig   = c >= "0" && c <= "9";
    assign diff     = pos_reg - tb_reg;

    // a keyword needs its candidate alive and the exact length
    assign word_kind = (kw_reg != sl_pkg::KW_NONE && kw_reg <= sl_pkg::KW_WHILE
                        && diff == ADDR_BITS'(sl_pkg::kw_len(kw_reg)))
                       ? sl_pkg::kw_kind(kw_reg) : sl_pkg::KIND_IDENT;

    // number ended by a dot that is not followed by a digit
    always_comb
    begin
        if (pos_reg == '0)
        begin
            dot_pos = '0;
            dot_len = (tb_reg == '0) ? '0 : LW'(sl_pkg::FIELD_MAX);
        end
        else
        begin
            dot_pos = pos_reg - ADDR_BITS'(1);
            dot_len = (diff == '0) ? LW'(sl_pkg::FIELD_MAX) : LW'(diff) - LW'(1);
        end
    end

    always_comb
    begin
        m_cnt     = 2'd0;
        m_tok0    = '0;
        m_tok1    = '0;
        i_en      = 1'b0;
        i_tok     = '0;
        to_idle   = 1'b1;
        ended     = 1'b0;
        line_inc  = 1'b0;
        mode_next = mode_reg;
        tb_next   = tb_reg;
        pend_next = pend_reg;
        kw_next   = kw_reg;

        unique case (mode_reg)
            M_IDENT:
            begin
                if (is_alpha || is_dig)
                begin
                    kw_next = sl_pkg::kw_step(kw_reg, diff < ADDR_BITS'(8), diff[2:0], c);
                    to_idle = 1'b0;
                end
                else
                begin
                    m_cnt  = 2'd1;
                    m_tok0 = mk(word_kind, LW'(tb_reg), LW'(diff), sl_pkg::ERR_NONE);
                end
            end
            M_NUMBER:
            begin
                if (is_dig)
                begin
                    to_idle = 1'b0;
                end
                else if (c == ".")
                begin
                    mode_next = M_NUMDOT;
                    to_idle   = 1'b0;
                end
                else
                begin
                    m_cnt  = 2'd1;
                    m_tok0 = mk(sl_pkg::KIND_NUMBER, LW'(tb_reg), LW'(diff), sl_pkg::ERR_NONE);
                end
            end
            M_NUMDOT:
            begin
                if (is_dig)
                begin
                    mode_next = M_FRAC;
                    to_idle   = 1'b0;
                end
                else
                begin
                    m_cnt  = 2'd2;
                    m_tok0 = mk(sl_pkg::KIND_NUMBER, LW'(tb_reg), dot_len, sl_pkg::ERR_NONE);
                    m_tok1 = mk(sl_pkg::KIND_DOT, LW'(dot_pos), LW'(1), sl_pkg::ERR_NONE);
                end
            end
            M_FRAC:
            begin
                if (is_dig)
                begin
                    to_idle = 1'b0;
                end
                else
                begin
                    m_cnt  = 2'd1;
                    m_tok0 = mk(sl_pkg::KIND_NUMBER, LW'(tb_reg), LW'(diff), sl_pkg::ERR_NONE);
                end
            end
            M_STRING:
            begin
                to_idle = 1'b0;
                if (c == "\"")
                begin
                    m_cnt     = 2'd1;
                    m_tok0    = mk(sl_pkg::KIND_STRING, LW'(tb_reg), LW'(diff) + LW'(1),
                                   sl_pkg::ERR_NONE);
                    mode_next = M_IDLE;
                end
                else if (c == 8'd0)
                begin
                    m_cnt   = 2'd1;
                    m_tok0  = mk(sl_pkg::KIND_ERROR, LW'(tb_reg), LW'(diff),
                                 sl_pkg::ERR_UNTERMINATED);
                    to_idle = 1'b1;
                end
                else if (c == "\n")
                begin
                    line_inc = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (c != "\n" && c != 8'd0)
                    to_idle = 1'b0;
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    mode_next = M_COMMENT;
                    to_idle   = 1'b0;
                end
                else
                begin
                    m_cnt  = 2'd1;
                    m_tok0 = mk(sl_pkg::KIND_SLASH, LW'(tb_reg), LW'(1), sl_pkg::ERR_NONE);
                end
            end
            M_OP2:
            begin
                if (c == sl_pkg::op_second(pend_reg))
                begin
                    m_cnt     = 2'd1;
                    m_tok0    = mk(sl_pkg::op_kind(pend_reg, 1'b1), LW'(tb_reg), LW'(2),
                                   sl_pkg::ERR_NONE);
                    mode_next = M_IDLE;
                    to_idle   = 1'b0;
                end
                else
                begin
                    m_cnt  = 2'd1;
                    m_tok0 = mk(sl_pkg::op_kind(pend_reg, 1'b0), LW'(tb_reg), LW'(1),
                                sl_pkg::ERR_NONE);
                end
            end
            default:
            begin
            end
        endcase

        // start of a fresh token from this byte
        if (to_idle)
        begin
            mode_next = M_IDLE;
            kw_next   = sl_pkg::KW_NONE;
            i_tok     = mk(sl_pkg::KIND_ERROR, LW'(pos_reg), LW'(1), sl_pkg::ERR_NONE);
            unique case (c)
                " ", CH_CR, "\t":
                begin
                end
                "\n": line_inc = 1'b1;
                8'd0:
                begin
                    i_en         = 1'b1;
                    i_tok.kind   = sl_pkg::KIND_EOF;
                    i_tok.token_length = '0;
                    ended        = 1'b1;
                end
                "(": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_LPAREN; end
                ")": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_RPAREN; end
                "{": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_LBRACE; end
                "}": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_RBRACE; end
                ",": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_COMMA;  end
                ".": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_DOT;    end
                "-": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_MINUS;  end
                "+": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_PLUS;   end
                ";": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_SEMI;   end
                "*": begin i_en = 1'b1; i_tok.kind = sl_pkg::KIND_STAR;   end
                "/":
                begin
                    tb_next   = pos_reg;
                    mode_next = M_SLASH;
                end
                "\"":
                begin
                    tb_next   = pos_reg;
                    mode_next = M_STRING;
                end
                "!", "=", ">", "<", "|", "&":
                begin
                    tb_next   = pos_reg;
                    pend_next = c;
                    mode_next = M_OP2;
                end
                default:
                begin
                    if (is_alpha)
                    begin
                        tb_next   = pos_reg;
                        kw_next   = sl_pkg::kw_first(c);
                        mode_next = M_IDENT;
                    end
                    else if (is_dig)
                    begin
                        tb_next   = pos_reg;
                        mode_next = M_NUMBER;
                    end
                    else
                    begin
                        i_en             = 1'b1;
                        i_tok.error_code = sl_pkg::ERR_UNEXPECTED;
                    end
                end
            endcase
        end

        // end of source returns everything to its reset value
        if (ended)
        begin
            mode_next = M_IDLE;
            pos_next  = '0;
            line_next = 24'd1;
            tb_next   = '0;
            pend_next = 8'd0;
            kw_next   = sl_pkg::KW_NONE;
        end
        else
        begin
            pos_next  = (pos_reg != '1) ? pos_reg + ADDR_BITS'(1) : pos_reg;
            line_next = (line_inc && line_reg != sl_pkg::FIELD_MAX) ? line_reg + 24'd1
                                                                    : line_reg;
        end
    end

    // pack the mode tokens first, the fresh-token result after them
    always_comb
    begin
        bundle.cnt         = m_cnt + {1'b0, i_en};
        bundle.line_number = line_reg;
        bundle.toks[0]     = (m_cnt == 2'd0) ? i_tok : m_tok0;
        bundle.toks[1]     = (m_cnt == 2'd2) ? m_tok1 : i_tok;
        bundle.toks[2]     = i_tok;
    end

    assign push = accept && (bundle.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            line_reg <= 24'd1;
            tb_reg   <= '0;
            pend_reg <= 8'd0;
            kw_reg   <= sl_pkg::KW_NONE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            tb_reg   <= tb_next;
            pend_reg <= pend_next;
            kw_reg   <= kw_next;
        end
    end

endmodule

FILE: rtl/sl_fifo.sv
// Short bundle queue between the scanner front end and the token back end.
`timescale 1ns / 1ps

module sl_fifo #(
    parameter int DEPTH = sl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sl_pkg::bundle_t  wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output sl_pkg::bundle_t  rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sl_pkg::bundle_t  mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("bundle pushed into full queue");
`endif

endmodule

FILE: rtl/sl_back.sv
// Token back end: unloads a bundle one token per word and marks the last.
`timescale 1ns / 1ps

module sl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  sl_pkg::bundle_t  rdata,
    output logic             pop,
    sl_token_if.source       tokens
);

    sl_pkg::bundle_t  cur_reg;
    logic             cur_valid_reg, cur_valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic             take, last_tok, done;
    sl_pkg::tok_t     tok;

    assign tok      = cur_reg.toks[idx_reg];
    assign last_tok = 2'(idx_reg + 2'd1) == cur_reg.cnt;
    assign take     = tokens.valid && tokens.ready;
    assign done     = take && last_tok;
    assign pop      = !empty && (!cur_valid_reg || done);

    assign tokens.valid        = cur_valid_reg;
    assign tokens.kind         = tok.kind;
    assign tokens.start_offset = tok.start_offset;
    assign tokens.token_length = tok.token_length;
    assign tokens.line_number  = cur_reg.line_number;
    assign tokens.error_code   = tok.error_code;
    assign tokens.last         = last_tok;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
            idx_next       = 2'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.cnt != 2'd0 && idx_reg < cur_reg.cnt))
        else $error("token index outside loaded bundle");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && !tokens.ready) |=> (tokens.valid && $stable(idx_reg)))
        else $error("token index moved while stalled");
`endif

endmodule

FILE: rtl/source_lexer.sv
// Streaming source lexer top level: front scanner, bundle queue, token back end.
//
// src carries one source byte per word (ch); a zero byte ends the source.
// tokens carries one token per word: kind, start_offset, token_length,
// line_number, error_code and last, which marks the final token a byte causes.
// Tokens that need look-ahead come out on the byte that follows them.
// The front scanner takes one byte per cycle while the queue has room and
// turns it into a bundle of zero to three tokens in the same cycle; bytes
// with no token leave no trace. A bundle waits in a QUEUE_DEPTH-entry queue;
// the back end loads it into its bundle register and sends one token per
// cycle while tokens.ready is high, so the first token of a byte passes the
// queue and then that register before it is offered. A byte that yields two
// or three tokens holds the output while they go out; otherwise the sustained
// rate is one byte per cycle while the receiver keeps up.
// src.ready drops only while the queue is full, so a stalled receiver backs
// up into the queue and then into the source. Reset empties the queue and
// sets the scanner idle at offset 0, line 1; a zero byte does only the latter.
`timescale 1ns / 1ps

module source_lexer #(
    parameter int ADDR_BITS   = sl_pkg::ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH = sl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sl_byte_if.sink     src,
    sl_token_if.source  tokens
);

    logic             push, full, pop, empty;
    sl_pkg::bundle_t  wdata, rdata;

    sl_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src),
        .full   (full),
        .push   (push),
        .bundle (wdata)
    );

    sl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (rdata)
    );

    sl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .rdata  (rdata),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

FILE: tb/sv/source_lexer_test.sv
// Self-checking testbench for the source lexer: byte driver, token monitor, token predictor.
`timescale 1ns / 1ps

module source_lexer_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 196;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_NUMDOT,
        SCAN_FRAC,
        SCAN_STRING,
        SCAN_COMMENT,
        SCAN_SLASH,
        SCAN_OP2
    } scan_mode_e;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [23:0] line_number;
        logic [1:0]  error_code;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } src_item_t;

    logic clk;
    logic rst_n;

    sl_byte_if  src_ch();
    sl_token_if tok_ch();

    source_lexer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src_ch),
        .tokens (tok_ch)
    );

    // lexer state as the predictor sees it
    scan_mode_e  lex_mode;
    logic [23:0] lex_pos;
    logic [23:0] lex_line;
    logic [23:0] lex_begin;
    logic [7:0]  lex_pend;
    logic [63:0] word_text;
    int          word_len;

    token_t    byte_toks[$];
    token_t    token_q[$];
    src_item_t src_q[$];

    int predicted_total = 0;
    int received_total  = 0;
    int fail_count      = 0;
    int cycle_count     = 0;
    bit calm            = 1'b0;
    bit next_drain      = 1'b0;
    int gen_count       = 0;

    int          src_gap = 0;
    bit          src_show;
    logic [7:0]  src_next;
    int          rx_gap  = 0;
    token_t      want_tok;

    string kw_words[8] = '{"else", "for", "function", "fn", "if", "return", "var", "while"};
    string op_words[23] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "/", "*",
                            "!", "!=", "=", "==", ">", ">=", "<", "<=", "|", "||", "&", "&&"};
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    logic [7:0] blanks[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void lexer_restart();
        lex_mode  = SCAN_IDLE;
        lex_pos   = '0;
        lex_line  = 24'd1;
        lex_begin = '0;
        lex_pend  = '0;
        word_text = '0;
        word_len  = 0;
    endfunction

    function automatic bit alpha_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // distance from one offset to another; a negative or oversized one pins at the top
    function automatic logic [23:0] span_len(logic [24:0] from_pos, logic [24:0] to_pos);
        logic [24:0] d;
        if (to_pos < from_pos)
            return sl_pkg::FIELD_MAX;
        d = to_pos - from_pos;
        return (d > 25'(sl_pkg::FIELD_MAX)) ? sl_pkg::FIELD_MAX : d[23:0];
    endfunction

    function automatic void bump_line();
        if (lex_line != sl_pkg::FIELD_MAX)
            lex_line++;
    endfunction

    function automatic void add_token(logic [5:0] kind, logic [23:0] start,
                                      logic [23:0] len, logic [1:0] err);
        token_t t;
        if (byte_toks.size() >= 3)
            return;
        t.kind         = kind;
        t.start_offset = start;
        t.token_length = len;
        t.line_number  = lex_line;
        t.error_code   = err;
        t.last         = 1'b0;
        byte_toks.push_back(t);
    endfunction

    // a word longer than eight characters can never be a keyword
    function automatic logic [5:0] word_kind();
        if (word_len > 8)
            return sl_pkg::KIND_IDENT;
        case (word_text)
            64'("else"):               return sl_pkg::KIND_ELSE;
            64'("for"):                return sl_pkg::KIND_FOR;
            64'("function"), 64'("fn"): return sl_pkg::KIND_FUNCTION;
            64'("if"):                 return sl_pkg::KIND_IF;
            64'("return"):             return sl_pkg::KIND_RETURN;
            64'("var"):                return sl_pkg::KIND_VAR;
            64'("while"):              return sl_pkg::KIND_WHILE;
            default:                   return sl_pkg::KIND_IDENT;
        endcase
    endfunction

    function automatic logic [7:0] pair_char(logic [7:0] first);
        return (first == "|" || first == "&") ? first : "=";
    endfunction

    function automatic logic [5:0] op_token(logic [7:0] first, bit paired);
        case (first)
            "!":     return paired ? sl_pkg::KIND_BANG_EQ : sl_pkg::KIND_BANG;
            "=":     return paired ? sl_pkg::KIND_EQ_EQ : sl_pkg::KIND_ASSIGN;
            ">":     return paired ? sl_pkg::KIND_GT_EQ : sl_pkg::KIND_GT;
            "<":     return paired ? sl_pkg::KIND_LT_EQ : sl_pkg::KIND_LT;
            "|":     return paired ? sl_pkg::KIND_PIPE_PIPE : sl_pkg::KIND_PIPE;
            default: return paired ? sl_pkg::KIND_AMP_AMP : sl_pkg::KIND_AMP;
        endcase
    endfunction

    // handle a byte between tokens; returns 1 on end of source
    function automatic bit start_token(logic [7:0] c, logic [23:0] p);
        case (c)
            CH_SPACE, CH_CR, CH_TAB: ;
            CH_LF: bump_line();
            CH_NUL:
            begin
                add_token(sl_pkg::KIND_EOF, p, 24'd0, sl_pkg::ERR_NONE);
                return 1'b1;
            end
            "(": add_token(sl_pkg::KIND_LPAREN, p, 24'd1, sl_pkg::ERR_NONE);
            ")": add_token(sl_pkg::KIND_RPAREN, p, 24'd1, sl_pkg::ERR_NONE);
            "{": add_token(sl_pkg::KIND_LBRACE, p, 24'd1, sl_pkg::ERR_NONE);
            "}": add_token(sl_pkg::KIND_RBRACE, p, 24'd1, sl_pkg::ERR_NONE);
            ",": add_token(sl_pkg::KIND_COMMA, p, 24'd1, sl_pkg::ERR_NONE);
            ".": add_token(sl_pkg::KIND_DOT, p, 24'd1, sl_pkg::ERR_NONE);
            "-": add_token(sl_pkg::KIND_MINUS, p, 24'd1, sl_pkg::ERR_NONE);
            "+": add_token(sl_pkg::KIND_PLUS, p, 24'd1, sl_pkg::ERR_NONE);
            ";": add_token(sl_pkg::KIND_SEMI, p, 24'd1, sl_pkg::ERR_NONE);
            "*": add_token(sl_pkg::KIND_STAR, p, 24'd1, sl_pkg::ERR_NONE);
            "/":
            begin
                lex_begin = p;
                lex_mode  = SCAN_SLASH;
            end
            CH_QUOTE:
            begin
                lex_begin = p;
                lex_mode  = SCAN_STRING;
            end
            "!", "=", ">", "<", "|", "&":
            begin
                lex_begin = p;
                lex_pend  = c;
                lex_mode  = SCAN_OP2;
            end
            default:
            begin
                if (alpha_char(c))
                begin
                    lex_begin = p;
                    word_text = {56'h0, c};
                    word_len  = 1;
                    lex_mode  = SCAN_IDENT;
                end
                else if (digit_char(c))
                begin
                    lex_begin = p;
                    lex_mode  = SCAN_NUMBER;
                end
                else
                    add_token(sl_pkg::KIND_ERROR, p, 24'd1, sl_pkg::ERR_UNEXPECTED);
            end
        endcase
        return 1'b0;
    endfunction

    // advance the predictor by one accepted byte and queue the tokens it yields
    function automatic void lex_byte(logic [7:0] c);
        logic [23:0] p;
        logic [23:0] dot;
        bit          go_idle;
        bit          ended;
        p       = lex_pos;
        go_idle = 1'b1;
        ended   = 1'b0;
        byte_toks.delete();
        case (lex_mode)
            SCAN_IDENT:
                if (alpha_char(c) || digit_char(c))
                begin
                    word_len++;
                    if (word_len <= 8)
                        word_text = {word_text[55:0], c};
                    go_idle = 1'b0;
                end
                else
                    add_token(word_kind(), lex_begin, p - lex_begin, sl_pkg::ERR_NONE);
            SCAN_NUMBER:
                if (digit_char(c))
                    go_idle = 1'b0;
                else if (c == ".")
                begin
                    lex_mode = SCAN_NUMDOT;
                    go_idle  = 1'b0;
                end
                else
                    add_token(sl_pkg::KIND_NUMBER, lex_begin, p - lex_begin, sl_pkg::ERR_NONE);
            SCAN_NUMDOT:
                if (digit_char(c))
                begin
                    lex_mode = SCAN_FRAC;
                    go_idle  = 1'b0;
                end
                else
                begin
                    // the dot was not a fraction: split it off as its own token
                    dot = (p != 24'd0) ? p - 24'd1 : 24'd0;
                    add_token(sl_pkg::KIND_NUMBER, lex_begin,
                              span_len(25'(lex_begin), 25'(dot)), sl_pkg::ERR_NONE);
                    add_token(sl_pkg::KIND_DOT, dot, 24'd1, sl_pkg::ERR_NONE);
                end
            SCAN_FRAC:
                if (digit_char(c))
                    go_idle = 1'b0;
                else
                    add_token(sl_pkg::KIND_NUMBER, lex_begin, p - lex_begin, sl_pkg::ERR_NONE);
            SCAN_STRING:
            begin
                go_idle = 1'b0;
                if (c == CH_QUOTE)
                begin
                    add_token(sl_pkg::KIND_STRING, lex_begin,
                              span_len(25'(lex_begin), 25'(p) + 25'd1), sl_pkg::ERR_NONE);
                    lex_mode = SCAN_IDLE;
                end
                else if (c == CH_NUL)
                begin
                    add_token(sl_pkg::KIND_ERROR, lex_begin, p - lex_begin,
                              sl_pkg::ERR_UNTERMINATED);
                    go_idle = 1'b1;
                end
                else if (c == CH_LF)
                    bump_line();
            end
            SCAN_COMMENT:
                if (c != CH_LF && c != CH_NUL)
                    go_idle = 1'b0;
            SCAN_SLASH:
                if (c == "/")
                begin
                    lex_mode = SCAN_COMMENT;
                    go_idle  = 1'b0;
                end
                else
                    add_token(sl_pkg::KIND_SLASH, lex_begin, 24'd1, sl_pkg::ERR_NONE);
            SCAN_OP2:
                if (c == pair_char(lex_pend))
                begin
                    add_token(op_token(lex_pend, 1'b1), lex_begin, 24'd2, sl_pkg::ERR_NONE);
                    lex_mode = SCAN_IDLE;
                    go_idle  = 1'b0;
                end
                else
                    add_token(op_token(lex_pend, 1'b0), lex_begin, 24'd1, sl_pkg::ERR_NONE);
            default: ;
        endcase
        if (go_idle)
        begin
            lex_mode = SCAN_IDLE;
            ended    = start_token(c, p);
        end
        if (ended)
            lexer_restart();
        else if (lex_pos != sl_pkg::FIELD_MAX)
            lex_pos++;
        if (byte_toks.size() > 0)
            byte_toks[byte_toks.size() - 1].last = 1'b1;
        foreach (byte_toks[i])
            token_q.push_back(byte_toks[i]);
        predicted_total += byte_toks.size();
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void push_ch(logic [7:0] b);
        src_item_t it;
        it.ch    = b;
        it.drain = next_drain;
        next_drain = 1'b0;
        src_q.push_back(it);
        gen_count++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_ch(s[i]);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_blank();
        return blanks[$urandom_range(0, 3)];
    endfunction

    function automatic void add_piece(bit at_end);
        int    sel;
        int    n;
        string w;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 18)
        begin
            // keywords and near misses
            w = kw_words[$urandom_range(0, 7)];
            case ($urandom_range(0, 3))
                0: w = w.substr(0, w.len() - 2);
                1: w = {w, string'(alnum[$urandom_range(0, 62)])};
                default: ;
            endcase
            if (w.len() == 0)
                w = "f";
            push_text(w);
        end
        else if (sel < 33)
        begin
            n = $urandom_range(1, 10);
            push_ch(alnum[$urandom_range(0, 52)]);
            repeat (n - 1)
                push_ch(alnum[$urandom_range(0, 62)]);
        end
        else if (sel < 45)
        begin
            repeat ($urandom_range(1, 4))
                push_ch(rand_digit());
            n = $urandom_range(0, 5);
            if (n >= 2)
                push_ch(".");
            if (n == 2 || n == 3)
                repeat ($urandom_range(1, 3))
                    push_ch(rand_digit());
        end
        else if (sel < 55)
        begin
            push_ch(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                b = 8'($urandom_range(1, 255));
                push_ch((b == CH_QUOTE) ? CH_LF : b);
            end
            if (!(at_end && $urandom_range(0, 1) == 0))
                push_ch(CH_QUOTE);
        end
        else if (sel < 62)
        begin
            push_text("//");
            repeat ($urandom_range(0, 8))
            begin
                b = 8'($urandom_range(1, 255));
                push_ch((b == CH_LF) ? "x" : b);
            end
            if (!(at_end && $urandom_range(0, 1) == 0))
                push_ch(CH_LF);
        end
        else if (sel < 85)
            push_text(op_words[$urandom_range(0, 22)]);
        else if (sel < 92)
            repeat ($urandom_range(1, 3))
                push_ch(rand_blank());
        else
            push_ch(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 2) != 0)
            push_ch(rand_blank());
    endfunction

    function automatic void build_source(bit drain_first);
        int n_pieces;
        n_pieces   = $urandom_range(3, 12);
        next_drain = drain_first;
        for (int k = 0; k < n_pieces; k++)
            add_piece(k == n_pieces - 1);
        push_ch(CH_NUL);
    endfunction

    // ---------------------------------------------------------------- byte driver

    always @(posedge clk)
    begin
        if (!rst_n)
            src_ch.valid <= 1'b0;
        else
        begin
            src_show = src_ch.valid;
            src_next = src_ch.ch;
            if (src_ch.valid && src_ch.ready)
            begin
                lex_byte(src_ch.ch);
                src_gap  = calm ? 0 : $urandom_range(0, 5);
                src_show = 1'b0;
            end
            if (!src_show)
            begin
                if (src_gap > 0)
                    src_gap--;
                // hold a draining word back until every token so far has come out
                else if (src_q.size() > 0 &&
                         !(src_q[0].drain && received_total < predicted_total))
                begin
                    src_show = 1'b1;
                    src_next = src_q[0].ch;
                    void'(src_q.pop_front());
                end
            end
            src_ch.valid <= src_show;
            src_ch.ch    <= src_next;
        end
    end

    // ---------------------------------------------------------------- token monitor

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            tok_ch.ready <= 1'b0;
        else
        begin
            if (tok_ch.valid && tok_ch.ready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           tok_ch.kind, tok_ch.start_offset, tok_ch.token_length);
                    fail_count++;
                end
                else
                begin
                    want_tok = token_q.pop_front();
                    check_field("kind", 24'(want_tok.kind), 24'(tok_ch.kind));
                    check_field("start_offset", want_tok.start_offset, tok_ch.start_offset);
                    check_field("token_length", want_tok.token_length, tok_ch.token_length);
                    check_field("line_number", want_tok.line_number, tok_ch.line_number);
                    check_field("error_code", 24'(want_tok.error_code),
                                24'(tok_ch.error_code));
                    check_field("last", 24'(want_tok.last), 24'(tok_ch.last));
                end
                received_total <= received_total + 1;
                rx_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                tok_ch.ready <= 1'b0;
            end
            else
                tok_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- cycle count, stall phases

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 40 == 0)
            calm <= ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL source_lexer");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n        = 1'b0;
        src_ch.valid = 1'b0;
        src_ch.ch    = CH_NUL;
        tok_ch.ready = 1'b0;
        lexer_restart();

        // empty source, keyword, pair operator, fraction, comment, number then dot,
        // string left open across a newline, out-of-set byte
        push_ch(CH_NUL);
        push_text("fn a==1.5//c\n12.)\"x\n");
        push_ch(CH_NUL);
        push_ch(8'hFF);
        push_ch(CH_NUL);

        gen_count = 0;
        build_source(1'b1);
        while (gen_count < RANDOM_BYTES)
            build_source($urandom_range(0, 3) == 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (src_q.size() != 0 || src_ch.valid || received_total < predicted_total)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && received_total == predicted_total && token_q.size() == 0)
            $display("PASS source_lexer");
        else
            $display("FAIL source_lexer");
        $finish;
    end

endmodule
